@@ rtl/fhd_pkg.sv @@
`timescale 1ns / 1ps

package fhd_pkg;

   localparam int CELL_W     = 20;
   localparam int OPC_W      = 2;
   localparam int COL_W      = 5;
   localparam int FUEL_W     = 8;
   localparam int LED_W      = 9;
   localparam int PAL_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COORD_W    = 6;
   localparam int LOSS_W     = 16;
   localparam int SHARE_W    = 8;
   localparam int SCALE_W    = 16;

   localparam int GRID_WIDTH_DEF      = 20;
   localparam int GRID_HEIGHT_DEF     = 17;
   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int MISSING_COL   = 13;
   localparam int FIRST_LED_ROW = 2;

   localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

   localparam logic [OPC_W-1:0] OP_FUEL = 2'd0;
   localparam logic [OPC_W-1:0] OP_STEP = 2'd1;
   localparam logic [OPC_W-1:0] OP_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LOSS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RISE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 3'd4;

   localparam logic [LOSS_W-1:0]  LOSS_RST   = 16'd58982;
   localparam logic [SHARE_W-1:0] KEEP_RST   = 8'd51;
   localparam logic [SHARE_W-1:0] RISE_RST   = 8'd154;
   localparam logic [SHARE_W-1:0] SPREAD_RST = 8'd26;
   localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd728;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_PRIME,
      ST_SWEEP,
      ST_CALC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               prime;
      logic               advance;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } stp_ctrl_type;

endpackage

@@ rtl/fire_heat_diffusion_grid.sv @@
`timescale 1ns / 1ps

// channel | direction | ports
// req     | in        | req_valid/req_ready, req_opcode req_column req_fuel_amount req_led_index
// rsp     | out       | rsp_valid/rsp_ready, rsp_palette_index
// csr     | in        | csr_we csr_index csr_wdata (write only)
//
// One word at a time: the idle state takes it, then a sweep rotates the ring once around.
// Step first primes in ST_PRIME; read LED first walks the columns in ST_MAP up to the LED's
// column and after the sweep scales in ST_CALC and ST_DONE. A read past the last LED walks all W
// columns, skips the ring and gives no word.
// Reset clears the ring at once, no clearing pass.
// A result waiting on rsp_ready holds the next read in its last cycle.
module fire_heat_diffusion_grid #(
   parameter int GRID_WIDTH      = fhd_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT     = fhd_pkg::GRID_HEIGHT_DEF,
   parameter int PALETTE_ENTRIES = fhd_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fhd_pkg::OPC_W-1:0]       req_opcode,
   input  logic [fhd_pkg::COL_W-1:0]       req_column,
   input  logic [fhd_pkg::FUEL_W-1:0]      req_fuel_amount,
   input  logic [fhd_pkg::LED_W-1:0]       req_led_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fhd_pkg::PAL_W-1:0]       rsp_palette_index,
   input  logic                            csr_we,
   input  logic [fhd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fhd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int POS_W = $clog2(CELLS);
   localparam int X_W   = $clog2(GRID_WIDTH);
   localparam int Y_W   = $clog2(GRID_HEIGHT);
   localparam int CW    = fhd_pkg::CELL_W;
   localparam int LW    = fhd_pkg::LED_W;
   localparam int TW    = CW + fhd_pkg::SCALE_W;
   localparam int SW    = 25;
   localparam int OW    = SW + fhd_pkg::PAL_W;

   fhd_pkg::state_type state_ff, state_in;

   logic [fhd_pkg::LOSS_W-1:0]  loss_ff;
   logic [fhd_pkg::SHARE_W-1:0] keep_ff, rise_ff, spread_ff;
   logic [fhd_pkg::SCALE_W-1:0] scale_ff;

   logic [fhd_pkg::OPC_W-1:0]  op_ff, op_in;
   logic [fhd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [fhd_pkg::FUEL_W-1:0] fuel_ff, fuel_in;
   logic [LW-1:0]              rem_ff, rem_in;
   logic [X_W-1:0]             mx_ff, mx_in;
   logic [POS_W-1:0]           tgt_ff, tgt_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [X_W-1:0]             x_ff, x_in;
   logic [Y_W-1:0]             y_ff, y_in;
   logic [CW-1:0]              cap_ff, cap_in;
   logic [SW-1:0]              t_ff, t_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [fhd_pkg::PAL_W-1:0]  pal_ff, pal_in;

   logic          shift, prime;
   logic [CW-1:0] head, next, tail_in, step_val, fuel_val;
   logic [CW:0]   fuel_sum;
   logic [LW-1:0] n_led, row_v;
   logic [TW-1:0] tprod;
   logic [OW-1:0] oprod;
   fhd_pkg::stp_ctrl_type ctrl;

   fhd_chain #(
      .CELLS (CELLS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .shift   (shift),
      .tail_in (tail_in),
      .head    (head),
      .next    (next)
   );

   assign ctrl.prime   = prime;
   assign ctrl.advance = shift && (op_ff == fhd_pkg::OP_STEP);
   assign ctrl.x       = fhd_pkg::COORD_W'(x_ff);
   assign ctrl.y       = fhd_pkg::COORD_W'(y_ff);

   fhd_stepper #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_stepper (
      .clock        (clock),
      .ctrl         (ctrl),
      .loss_factor  (loss_ff),
      .keep_share   (keep_ff),
      .rise_share   (rise_ff),
      .spread_share (spread_ff),
      .head         (head),
      .next         (next),
      .new_val      (step_val)
   );

   assign fuel_sum = (CW+1)'(head) + (CW+1)'({fuel_ff, 8'd0});
   assign fuel_val = fuel_sum[CW] ? fhd_pkg::CELL_MAX : fuel_sum[CW-1:0];

   always_comb begin
      unique case (op_ff)
         fhd_pkg::OP_STEP: tail_in = step_val;
         fhd_pkg::OP_FUEL:
            tail_in = (POS_W'(col_ff) == pos_ff && 32'(col_ff) < GRID_WIDTH) ? fuel_val : head;
         default: tail_in = head;
      endcase
   end

   // column 13 is one LED short
   assign n_led = (fhd_pkg::COORD_W'(mx_ff) == fhd_pkg::COORD_W'(fhd_pkg::MISSING_COL)) ?
                  LW'(GRID_HEIGHT - 3) : LW'(GRID_HEIGHT - 2);
   assign row_v = LW'(fhd_pkg::FIRST_LED_ROW) + (mx_ff[0] ? (n_led - 1'b1 - rem_ff) : rem_ff);

   assign tprod = TW'(cap_ff) * TW'(scale_ff);
   assign oprod = OW'(t_ff) * OW'(PALETTE_ENTRIES - 1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      fuel_in      = fuel_ff;
      rem_in       = rem_ff;
      mx_in        = mx_ff;
      tgt_in       = tgt_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cap_in       = cap_ff;
      t_in         = t_ff;
      pal_in       = pal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      shift        = 1'b0;
      prime        = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         fhd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_opcode;
               col_in  = req_column;
               fuel_in = req_fuel_amount;
               rem_in  = req_led_index;
               mx_in   = '0;
               pos_in  = '0;
               x_in    = '0;
               y_in    = '0;
               priority case (req_opcode)
                  fhd_pkg::OP_READ: state_in = fhd_pkg::ST_MAP;
                  fhd_pkg::OP_STEP: state_in = fhd_pkg::ST_PRIME;
                  default:          state_in = fhd_pkg::ST_SWEEP;
               endcase
            end
         end
         fhd_pkg::ST_MAP: begin
            if (rem_ff < n_led) begin
               tgt_in   = POS_W'(32'(row_v) * GRID_WIDTH + 32'(mx_ff));
               state_in = fhd_pkg::ST_SWEEP;
            end else if (32'(mx_ff) == GRID_WIDTH - 1) begin
               state_in = fhd_pkg::ST_IDLE;
            end else begin
               rem_in = rem_ff - n_led;
               mx_in  = mx_ff + 1'b1;
            end
         end
         fhd_pkg::ST_PRIME: begin
            prime    = 1'b1;
            state_in = fhd_pkg::ST_SWEEP;
         end
         fhd_pkg::ST_SWEEP: begin
            shift = 1'b1;
            if (pos_ff == tgt_ff) begin
               cap_in = head;
            end
            pos_in = pos_ff + 1'b1;
            if (32'(x_ff) == GRID_WIDTH - 1) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
            if (32'(pos_ff) == CELLS - 1) begin
               state_in = (op_ff == fhd_pkg::OP_READ) ? fhd_pkg::ST_CALC : fhd_pkg::ST_IDLE;
            end
         end
         fhd_pkg::ST_CALC: begin
            t_in     = (tprod > TW'(1 << 24)) ? SW'(1 << 24) : tprod[SW-1:0];
            state_in = fhd_pkg::ST_DONE;
         end
         fhd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               pal_in       = oprod[24 +: fhd_pkg::PAL_W];
               rsp_valid_in = 1'b1;
               state_in     = fhd_pkg::ST_IDLE;
            end
         end
         default: state_in = fhd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fhd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      col_ff  <= col_in;
      fuel_ff <= fuel_in;
      rem_ff  <= rem_in;
      mx_ff   <= mx_in;
      tgt_ff  <= tgt_in;
      pos_ff  <= pos_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cap_ff  <= cap_in;
      t_ff    <= t_in;
      pal_ff  <= pal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_ff   <= fhd_pkg::LOSS_RST;
         keep_ff   <= fhd_pkg::KEEP_RST;
         rise_ff   <= fhd_pkg::RISE_RST;
         spread_ff <= fhd_pkg::SPREAD_RST;
         scale_ff  <= fhd_pkg::SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            fhd_pkg::REG_LOSS:   loss_ff   <= csr_wdata;
            fhd_pkg::REG_KEEP:   keep_ff   <= csr_wdata[fhd_pkg::SHARE_W-1:0];
            fhd_pkg::REG_RISE:   rise_ff   <= csr_wdata[fhd_pkg::SHARE_W-1:0];
            fhd_pkg::REG_SPREAD: spread_ff <= csr_wdata[fhd_pkg::SHARE_W-1:0];
            fhd_pkg::REG_SCALE:  scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = pal_ff;

endmodule

@@ rtl/fhd_cell.sv @@
`timescale 1ns / 1ps

module fhd_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic [fhd_pkg::CELL_W-1:0] d,
   output logic [fhd_pkg::CELL_W-1:0] q
);

   logic [fhd_pkg::CELL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (shift) begin
         val_ff <= d;
      end
   end

   assign q = val_ff;

endmodule

@@ rtl/fhd_chain.sv @@
`timescale 1ns / 1ps

// Ring of temperature cells; cell 0 is the head, the tail is fed from outside.
module fhd_chain #(
   parameter int CELLS = fhd_pkg::GRID_WIDTH_DEF * fhd_pkg::GRID_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic [fhd_pkg::CELL_W-1:0] tail_in,
   output logic [fhd_pkg::CELL_W-1:0] head,
   output logic [fhd_pkg::CELL_W-1:0] next
);

   logic [fhd_pkg::CELL_W-1:0] q [CELLS];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == CELLS - 1) begin : g_tail
         fhd_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     (tail_in),
            .q     (q[i])
         );
      end else begin : g_body
         fhd_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     (q[i+1]),
            .q     (q[i])
         );
      end
   end

   assign head = q[0];
   assign next = q[1];

endmodule

@@ rtl/fhd_stepper.sv @@
`timescale 1ns / 1ps

// Diffusion datapath: damped value of the head cell, its shares, and a line of
// recent rise/spread shares from which the upper neighbors collect.
module fhd_stepper #(
   parameter int GRID_WIDTH  = fhd_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = fhd_pkg::GRID_HEIGHT_DEF
) (
   input  logic                          clock,
   input  fhd_pkg::stp_ctrl_type         ctrl,
   input  logic [fhd_pkg::LOSS_W-1:0]    loss_factor,
   input  logic [fhd_pkg::SHARE_W-1:0]   keep_share,
   input  logic [fhd_pkg::SHARE_W-1:0]   rise_share,
   input  logic [fhd_pkg::SHARE_W-1:0]   spread_share,
   input  logic [fhd_pkg::CELL_W-1:0]    head,
   input  logic [fhd_pkg::CELL_W-1:0]    next,
   output logic [fhd_pkg::CELL_W-1:0]    new_val
);

   localparam int CW     = fhd_pkg::CELL_W;
   localparam int LINE_N = 2 * GRID_WIDTH - 1;
   localparam int DW     = CW + fhd_pkg::LOSS_W;
   localparam int PW     = CW + fhd_pkg::SHARE_W;

   logic [CW-1:0] d_ff, d_in;
   logic [CW-1:0] rise_ff [LINE_N];
   logic [CW-1:0] sp_ff   [LINE_N];
   logic [DW-1:0] dprod;
   logic [CW-1:0] dsrc;
   logic [PW-1:0] kprod, rprod, sprod;
   logic [CW-1:0] keep_p, rise_p, sp_p;
   logic [CW-1:0] left_p, right_p;
   logic [CW+1:0] sum;
   logic          at_left, at_right, bottom, top;

   assign dsrc  = ctrl.prime ? head : next;
   assign dprod = DW'(dsrc) * DW'(loss_factor);
   assign d_in  = dprod[DW-1:fhd_pkg::LOSS_W];

   assign kprod  = PW'(d_ff) * PW'(keep_share);
   assign rprod  = PW'(d_ff) * PW'(rise_share);
   assign sprod  = PW'(d_ff) * PW'(spread_share);
   assign keep_p = kprod[PW-1:fhd_pkg::SHARE_W];
   assign rise_p = rprod[PW-1:fhd_pkg::SHARE_W];
   assign sp_p   = sprod[PW-1:fhd_pkg::SHARE_W];

   assign at_left  = ctrl.x == '0;
   assign at_right = ctrl.x == fhd_pkg::COORD_W'(GRID_WIDTH - 1);
   assign bottom   = ctrl.y == '0;
   assign top      = ctrl.y == fhd_pkg::COORD_W'(GRID_HEIGHT - 1);

   // line entry k holds the share of the cell k+1 places back in sweep order
   assign left_p  = at_left  ? sp_ff[0] : sp_ff[GRID_WIDTH];
   assign right_p = at_right ? sp_ff[2*GRID_WIDTH-2] : sp_ff[GRID_WIDTH-2];

   always_comb begin
      sum = '0;
      if (!top) begin
         sum = sum + (CW+2)'(keep_p);
      end
      if (!bottom) begin
         sum = sum + (CW+2)'(rise_ff[GRID_WIDTH-1]) + (CW+2)'(left_p) + (CW+2)'(right_p);
      end
      new_val = (sum > (CW+2)'(fhd_pkg::CELL_MAX)) ? fhd_pkg::CELL_MAX : sum[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.prime || ctrl.advance) begin
         d_ff <= d_in;
      end
      if (ctrl.advance) begin
         rise_ff[0] <= rise_p;
         sp_ff[0]   <= sp_p;
         for (int k = 1; k < LINE_N; k++) begin
            rise_ff[k] <= rise_ff[k-1];
            sp_ff[k]   <= sp_ff[k-1];
         end
      end
   end

endmodule

@@ rtl/fhd_checker.sv @@
`timescale 1ns / 1ps

module fhd_props (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [fhd_pkg::PAL_W-1:0] rsp_palette_index
);

   // one word in flight: ready drops right after a word is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready held after accept");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_palette_index))
      else $error("rsp word changed while stalled");

   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back-to-back result words");

   a_rst: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind fire_heat_diffusion_grid fhd_props u_fhd_props (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_palette_index (rsp_palette_index)
);

@@ test/fhd_checker.sv @@
`timescale 1ns / 1ps

module fhd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [fhd_pkg::OPC_W-1:0]      req_opcode,
   input  logic [fhd_pkg::COL_W-1:0]      req_column,
   input  logic [fhd_pkg::FUEL_W-1:0]     req_fuel_amount,
   input  logic [fhd_pkg::LED_W-1:0]      req_led_index,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [fhd_pkg::PAL_W-1:0]      rsp_palette_index,
   input  logic                           csr_we,
   input  logic [fhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fhd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_reads
);

   localparam int GW = fhd_pkg::GRID_WIDTH_DEF;
   localparam int GH = fhd_pkg::GRID_HEIGHT_DEF;
   localparam int NCELL = GW * GH;
   localparam int CW = fhd_pkg::CELL_W;

   logic [CW-1:0]               temp_grid [NCELL];
   logic [fhd_pkg::LOSS_W-1:0]  loss_q;
   logic [fhd_pkg::SHARE_W-1:0] keep_q, rise_q, spread_q;
   logic [fhd_pkg::SCALE_W-1:0] scale_q;
   logic [fhd_pkg::PAL_W-1:0]   palette_q [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [CW-1:0] clip_cell(input longint unsigned v);
      return (v > 64'(fhd_pkg::CELL_MAX)) ? fhd_pkg::CELL_MAX : v[CW-1:0];
   endfunction

   task automatic diffuse_grid();
      longint unsigned sum [NCELL];
      longint unsigned d, sp;
      int up;
      for (int i = 0; i < NCELL; i++) sum[i] = 0;
      for (int y = 0; y < GH - 1; y++)
         for (int x = 0; x < GW; x++) begin
            d = (longint'(temp_grid[y*GW+x]) * loss_q) >> 16;
            sp = (d * spread_q) >> 8;
            up = (y + 1) * GW;
            sum[y*GW+x] += (d * keep_q) >> 8;
            sum[up+x] += (d * rise_q) >> 8;
            sum[up+(x+1)%GW] += sp;
            sum[up+(x+GW-1)%GW] += sp;
         end
      for (int i = 0; i < NCELL; i++) temp_grid[i] = clip_cell(sum[i]);
   endtask

   // serpentine LED walk; column 13 is one short
   function automatic int led_to_cell(input int idx);
      int n, row;
      for (int x = 0; x < GW; x++) begin
         n = (x == fhd_pkg::MISSING_COL) ? GH - 3 : GH - 2;
         if (idx < n) begin
            row = fhd_pkg::FIRST_LED_ROW + ((x % 2 == 0) ? idx : (n - 1 - idx));
            return row * GW + x;
         end
         idx -= n;
      end
      return -1;
   endfunction

   always @(posedge clock) begin
      int cell_no;
      longint unsigned t;
      if (reset) begin
         for (int i = 0; i < NCELL; i++) temp_grid[i] = '0;
         loss_q = fhd_pkg::LOSS_RST; keep_q = fhd_pkg::KEEP_RST; rise_q = fhd_pkg::RISE_RST;
         spread_q = fhd_pkg::SPREAD_RST; scale_q = fhd_pkg::SCALE_RST;
         palette_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we)
            case (csr_index)
               fhd_pkg::REG_LOSS:   loss_q = csr_wdata;
               fhd_pkg::REG_KEEP:   keep_q = csr_wdata[fhd_pkg::SHARE_W-1:0];
               fhd_pkg::REG_RISE:   rise_q = csr_wdata[fhd_pkg::SHARE_W-1:0];
               fhd_pkg::REG_SPREAD: spread_q = csr_wdata[fhd_pkg::SHARE_W-1:0];
               fhd_pkg::REG_SCALE:  scale_q = csr_wdata;
               default: ;
            endcase
         if (req_valid && req_ready)
            case (req_opcode)
               fhd_pkg::OP_FUEL: begin
                  if (req_column < GW)
                     temp_grid[req_column] = clip_cell(longint'(temp_grid[req_column])
                        + (longint'(req_fuel_amount) << 8));
               end
               fhd_pkg::OP_STEP: diffuse_grid();
               fhd_pkg::OP_READ: begin
                  cell_no = led_to_cell(req_led_index);
                  if (cell_no >= 0) begin
                     t = longint'(temp_grid[cell_no]) * scale_q;
                     if (t > (64'd1 << 24)) t = 64'd1 << 24;
                     palette_q.push_back(fhd_pkg::PAL_W'(
                        ((fhd_pkg::PALETTE_ENTRIES_DEF - 1) * t) >> 24));
                  end
               end
               default: ;
            endcase
         if (rsp_valid && rsp_ready) begin
            if (palette_q.size() == 0)
               report_mismatch("unexpected palette word");
            else begin
               logic [fhd_pkg::PAL_W-1:0] want;
               want = palette_q.pop_front();
               if (rsp_palette_index !== want)
                  report_mismatch($sformatf("palette_index got %0d want %0d",
                     rsp_palette_index, want));
            end
         end
      end
      pending_reads <= palette_q.size();
   end

endmodule

@@ test/tb_fire_heat_diffusion_grid.sv @@
`timescale 1ns / 1ps

module tb_fire_heat_diffusion_grid;

   localparam logic [fhd_pkg::OPC_W-1:0]     OP_NONE  = 2'd3;
   localparam logic [fhd_pkg::CSR_IDX_W-1:0] REG_NONE = 3'd7;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [fhd_pkg::OPC_W-1:0]      req_opcode = '0;
   logic [fhd_pkg::COL_W-1:0]      req_column = '0;
   logic [fhd_pkg::FUEL_W-1:0]     req_fuel_amount = '0;
   logic [fhd_pkg::LED_W-1:0]      req_led_index = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [fhd_pkg::PAL_W-1:0]      rsp_palette_index;
   logic                           csr_we = 1'b0;
   logic [fhd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fhd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                             fail_count;
   int                             pending_reads;
   int                             cycle_count = 0;
   int                             stall_left = 0;
   bit                             calm_tail = 0;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 800;

   fire_heat_diffusion_grid u_top (.*);

   fhd_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // sink stalls in random bursts, and is ready again before each new burst
   always @(posedge clock) begin
      if (calm_tail || reset) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_ready && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input logic [fhd_pkg::OPC_W-1:0] op, input int col,
                            input int fuel, input int led);
      int gap;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_column <= fhd_pkg::COL_W'(col);
      req_fuel_amount <= fhd_pkg::FUEL_W'(fuel);
      req_led_index <= fhd_pkg::LED_W'(led);
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      // the block stays busy after taking a word, so this wait costs nothing
      @(posedge clock);
   endtask

   task automatic settle();
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [fhd_pkg::CSR_IDX_W-1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= fhd_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) send_word(fhd_pkg::OP_FUEL, $urandom_range(0, 19), $urandom_range(0, 255),
                            $urandom_range(0, 511));
      else if (r < 55) send_word(fhd_pkg::OP_STEP, $urandom_range(0, 31),
                                 $urandom_range(0, 255), $urandom_range(0, 511));
      else if (r < 92) send_word(fhd_pkg::OP_READ, $urandom_range(0, 31),
                                 $urandom_range(0, 255), $urandom_range(0, 298));
      else if (r < 96) send_word(fhd_pkg::OP_FUEL, $urandom_range(20, 31),
                                 $urandom_range(0, 255), 0);
      else if (r < 98) send_word(fhd_pkg::OP_READ, 0, 0, $urandom_range(299, 511));
      else send_word(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 255),
                     $urandom_range(0, 511));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturation, bounds, serpentine corners, missing LED
      for (int i = 0; i < 6; i++) send_word(fhd_pkg::OP_FUEL, 0, 255, 0);
      send_word(fhd_pkg::OP_FUEL, 19, 255, 0);
      send_word(fhd_pkg::OP_FUEL, 20, 255, 0);
      send_word(fhd_pkg::OP_FUEL, 31, 128, 0);
      send_word(fhd_pkg::OP_READ, 0, 0, 0);
      send_word(OP_NONE, 5, 5, 5);
      for (int i = 0; i < 4; i++) send_word(fhd_pkg::OP_STEP, 0, 0, 0);
      send_word(fhd_pkg::OP_READ, 0, 0, 14);
      send_word(fhd_pkg::OP_READ, 0, 0, 15);
      send_word(fhd_pkg::OP_READ, 0, 0, 207);
      send_word(fhd_pkg::OP_READ, 0, 0, 208);
      send_word(fhd_pkg::OP_READ, 0, 0, 209);
      send_word(fhd_pkg::OP_READ, 0, 0, 298);
      send_word(fhd_pkg::OP_READ, 0, 0, 299);
      send_word(fhd_pkg::OP_READ, 0, 0, 511);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_reg(fhd_pkg::REG_LOSS, 16'hFFFF); write_reg(fhd_pkg::REG_KEEP, 255);
               write_reg(fhd_pkg::REG_RISE, 255); write_reg(fhd_pkg::REG_SPREAD, 255);
               write_reg(fhd_pkg::REG_SCALE, 16'hFFFF);
            end
            1: begin
               write_reg(fhd_pkg::REG_LOSS, 0); write_reg(fhd_pkg::REG_KEEP, 0);
               write_reg(fhd_pkg::REG_RISE, 0); write_reg(fhd_pkg::REG_SPREAD, 0);
               write_reg(fhd_pkg::REG_SCALE, 0);
            end
            2: begin
               write_reg(fhd_pkg::REG_LOSS, fhd_pkg::LOSS_RST);
               write_reg(fhd_pkg::REG_KEEP, fhd_pkg::KEEP_RST);
               write_reg(fhd_pkg::REG_RISE, fhd_pkg::RISE_RST);
               write_reg(fhd_pkg::REG_SPREAD, fhd_pkg::SPREAD_RST);
               write_reg(fhd_pkg::REG_SCALE, fhd_pkg::SCALE_RST);
               write_reg(REG_NONE, 16'h1234);
            end
            default: begin
               write_reg(fhd_pkg::REG_LOSS, $urandom_range(0, 65535));
               write_reg(fhd_pkg::REG_KEEP, $urandom_range(0, 65535));
               write_reg(fhd_pkg::REG_RISE, $urandom_range(0, 255));
               write_reg(fhd_pkg::REG_SPREAD, $urandom_range(0, 255));
               write_reg(fhd_pkg::REG_SCALE, $urandom_range(0, 65535));
            end
         endcase
         if (phase == 4) calm_tail = 1;
         for (int i = 0; i < 106; i++) begin
            random_word();
            // hold off until the sink has drained
            if (i == 50) while (pending_reads != 0) @(posedge clock);
         end
         settle();
      end

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fhd_pkg.sv
rtl/fhd_cell.sv
rtl/fhd_chain.sv
rtl/fhd_stepper.sv
rtl/fire_heat_diffusion_grid.sv
rtl/fhd_checker.sv
test/fhd_checker.sv
test/tb_fire_heat_diffusion_grid.sv
